/* hw/rtl/double_ended_queue_unit_macros.svh */
// Assertion helpers for the deque unit. Both sample on clk_i and are
// disabled while rst_ni is low.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Invariant that must hold at every rising clock edge.
`define DQU_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DQU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dq_pkg.sv */
package dq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Response control registered at the end of each transaction.
  typedef struct packed {
    logic    valid;
    status_e status;
    logic    rd_sel;   // read data comes from the memory port
  } resp_t;

endpackage

/* hw/rtl/dq_mem.sv */
module dq_mem #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(CAPACITY)-1:0] waddr_i,
  input  logic [ELEMENT_WIDTH-1:0]    wdata_i,
  input  logic                        re_i,
  input  logic [$clog2(CAPACITY)-1:0] raddr_i,
  output logic [ELEMENT_WIDTH-1:0]    rdata_o
);

  logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/dq_ctrl.sv */
`include "double_ended_queue_unit_macros.svh"

module dq_ctrl #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32,
  localparam int PW           = $clog2(CAPACITY),
  localparam int CW           = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [2:0]               operation_i,
  input  logic [31:0]              push_value_i,
  input  logic [5:0]               position_i,
  output logic                     mem_we_o,
  output logic [PW-1:0]            mem_waddr_o,
  output logic [ELEMENT_WIDTH-1:0] mem_wdata_o,
  output logic                     mem_re_o,
  output logic [PW-1:0]            mem_raddr_o,
  output dq_pkg::resp_t            resp_o,
  output logic [CW-1:0]            count_o
);

  localparam logic [PW:0]   CapP = (PW + 1)'(CAPACITY);
  localparam logic [PW-1:0] LastIdx = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  logic [PW-1:0]  front_q, front_d;
  logic [CW-1:0]  count_q, count_d;
  dq_pkg::resp_t  resp_q, resp_d;

  logic                       full, empty;
  logic [CW+5:0]              pos_ext, cnt_ext;
  logic [ELEMENT_WIDTH+31:0]  pv_ext;
  logic [PW-1:0]              back_addr, front_dec, front_inc, rd_addr;

  // a, b < CAPACITY: one conditional subtract wraps the sum
  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CapP) begin
      s = s - CapP;
    end
    return s[PW-1:0];
  endfunction

  assign full    = (count_q == CapC);
  assign empty   = (count_q == '0);
  assign pos_ext = {{CW{1'b0}}, position_i};
  assign cnt_ext = {6'd0, count_q};
  assign pv_ext  = {{ELEMENT_WIDTH{1'b0}}, push_value_i};

  assign back_addr = ring_add(front_q, count_q[PW-1:0]);
  assign rd_addr   = ring_add(front_q, pos_ext[PW-1:0]);
  assign front_dec = (front_q == '0) ? LastIdx : front_q - 1'b1;
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + 1'b1;

  always_comb begin
    front_d       = front_q;
    count_d       = count_q;
    resp_d.valid  = accept_i;
    resp_d.status = dq_pkg::ST_OK;
    resp_d.rd_sel = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = back_addr;
    mem_wdata_o   = pv_ext[ELEMENT_WIDTH-1:0];
    mem_re_o      = 1'b0;
    mem_raddr_o   = rd_addr;
    if (accept_i) begin
      case (dq_pkg::op_e'(operation_i))
        dq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            resp_d.status = dq_pkg::ST_FULL;
          end else begin
            mem_we_o = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        dq_pkg::OP_PUSH_FRONT: begin
          mem_waddr_o = front_dec;
          if (full) begin
            resp_d.status = dq_pkg::ST_FULL;
          end else begin
            mem_we_o = 1'b1;
            front_d  = front_dec;
            count_d  = count_q + 1'b1;
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (empty) begin
            resp_d.status = dq_pkg::ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            resp_d.status = dq_pkg::ST_EMPTY;
          end else begin
            front_d = front_inc;
            count_d = count_q - 1'b1;
          end
        end
        dq_pkg::OP_READ: begin
          if (empty) begin
            resp_d.status = dq_pkg::ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            resp_d.status = dq_pkg::ST_RANGE;
          end else begin
            mem_re_o      = 1'b1;
            resp_d.rd_sel = 1'b1;
          end
        end
        dq_pkg::OP_CLEAR: begin
          front_d = '0;
          count_d = '0;
        end
        default: begin
          // unused codes: no effect
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      resp_q  <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      resp_q  <= resp_d;
    end
  end

  assign resp_o  = resp_q;
  assign count_o = count_q;

  `DQU_ASSERT_ALWAYS(a_count_bound, count_q <= CapC, "element count exceeds capacity")
  `DQU_ASSERT_ALWAYS(a_front_bound, front_q <= LastIdx, "front index outside ring")
  `DQU_ASSERT_NEXT(a_resp_follows, accept_i, resp_q.valid, "accepted transaction gave no response")
  `DQU_ASSERT_NEXT(a_full_holds, accept_i && full && (operation_i == dq_pkg::OP_PUSH_BACK || operation_i == dq_pkg::OP_PUSH_FRONT), count_q == CapC && resp_q.status == dq_pkg::ST_FULL, "push into full queue changed state")
  `DQU_ASSERT_ALWAYS(a_rdsel_ok, !resp_q.rd_sel || (resp_q.valid && resp_q.status == dq_pkg::ST_OK), "read data selected on failed response")

endmodule

/* hw/rtl/double_ended_queue_unit.sv */
// Double-ended queue unit: a ring of CAPACITY elements in one synchronous RAM.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low. operation_i selects push back/front, pop back/front, indexed read
// (position_i counted from the front) or clear; push_value_i carries the data.
// busy is always low: the unit never holds off a command, so a new command
// may be issued every cycle.
// Result channel: exactly one result per command, on done_o for one cycle,
// registered at the command edge (up to one result per cycle).
// status_o gives ok / empty / full / index out of range, count_after_o the
// element count after the command, read_value_o the element for a good read
// and zero otherwise. Read data comes straight from the RAM output register,
// so the RAM read port sets the latency.
// The receiver cannot stall; results must be taken when done_o is high.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending
// result. RAM contents are not cleared; unwritten entries are never readable.
module double_ended_queue_unit #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation_i,
  input  logic [31:0] push_value_i,
  input  logic [5:0]  position_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [6:0]  count_after_o,
  output logic [31:0] read_value_o
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                     accept;
  logic                     mem_we, mem_re;
  logic [PW-1:0]            mem_waddr, mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_rdata;
  dq_pkg::resp_t            resp;
  logic [CW-1:0]            count;
  logic [CW+6:0]            count_ext;
  logic [ELEMENT_WIDTH+31:0] rdata_ext;

  // Every command completes in one RAM cycle, so the unit never holds off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  dq_ctrl #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .position_i   (position_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .resp_o       (resp),
    .count_o      (count)
  );

  dq_mem #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Count register already holds the post-command value in the result cycle.
  assign count_ext     = {7'd0, count};
  assign rdata_ext     = {32'd0, mem_rdata};

  assign done_o        = resp.valid;
  assign status_o      = resp.status;
  assign count_after_o = count_ext[6:0];
  assign read_value_o  = resp.rd_sel ? rdata_ext[31:0] : 32'd0;

endmodule
